// ===== hdl/fwkc_pkg.sv =====
// ============================================================================
// fwkc_pkg
// shared types and constants of the key queue with count and purge
// ============================================================================
package fwkc_pkg;

    // default sizes
    localparam int DEPTH_DEF    = 32;
    localparam int KEY_BITS_DEF = 16;

    // fixed field widths of the transfer payloads
    localparam int KEY_W = 16;
    localparam int CNT_W = 6;

    // reset value of the limit register
    localparam logic [CNT_W-1:0] LIMIT_RESET = 6'd32;

    typedef enum logic [1:0] {
        OP_ENQUEUE = 2'd0,
        OP_DEQUEUE = 2'd1,
        OP_COUNT   = 2'd2,
        OP_PURGE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        t_op              operation;
        logic [KEY_W-1:0] key;
    } t_in_item;

    typedef struct packed {
        t_status          status;
        logic [KEY_W-1:0] key_out;
        logic [CNT_W-1:0] match_count;
        logic [CNT_W-1:0] level;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic enq_write;
        logic set_full;
        logic set_empty;
        logic deq_read;
        logic deq_take;
        logic scan_init;
        logic scan_read;
        logic commit;
        logic respond;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        t_op  op;
        logic full;
        logic empty;
        logic scan_last;
    } t_sts;

endpackage

// ===== hdl/fwkc_ram.sv =====
// ============================================================================
// fwkc_ram
// simple dual-port ram, one write and one registered read per cycle
// ============================================================================
module fwkc_ram #(
    parameter int WIDTH = fwkc_pkg::KEY_BITS_DEF,
    parameter int DEPTH = fwkc_pkg::DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/fwkc_ctrl.sv =====
// ============================================================================
// fwkc_ctrl
// sequencer for enqueue, dequeue and the count / purge walk
// ============================================================================
module fwkc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  fwkc_pkg::t_sts i_sts,
    output fwkc_pkg::t_cmd o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_EXEC     = 7'b0000010,
        S_DEQ_WAIT = 7'b0000100,
        S_SCAN     = 7'b0001000,
        S_DRAIN    = 7'b0010000,
        S_COMMIT   = 7'b0100000,
        S_FINISH   = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                case (i_sts.op)
                    fwkc_pkg::OP_ENQUEUE: begin
                        if (i_sts.full) begin
                            o_cmd.set_full = 1'b1;
                        end else begin
                            o_cmd.enq_write = 1'b1;
                        end
                        n_state = S_FINISH;
                    end
                    fwkc_pkg::OP_DEQUEUE: begin
                        if (i_sts.empty) begin
                            o_cmd.set_empty = 1'b1;
                            n_state         = S_FINISH;
                        end else begin
                            o_cmd.deq_read = 1'b1;
                            n_state        = S_DEQ_WAIT;
                        end
                    end
                    default: begin
                        // count and purge on an empty queue finish at once
                        if (i_sts.empty) begin
                            n_state = S_FINISH;
                        end else begin
                            o_cmd.scan_init = 1'b1;
                            n_state         = S_SCAN;
                        end
                    end
                endcase
            end
            S_DEQ_WAIT: begin
                o_cmd.deq_take = 1'b1;
                n_state        = S_FINISH;
            end
            S_SCAN: begin
                o_cmd.scan_read = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_FINISH;
            end
            S_FINISH: begin
                o_cmd.respond = 1'b1;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

// ===== hdl/fwkc_dp.sv =====
// ============================================================================
// fwkc_dp
// key store, ring pointers, counters and result register
// ============================================================================
module fwkc_dp #(
    parameter int DEPTH    = fwkc_pkg::DEPTH_DEF,
    parameter int KEY_BITS = fwkc_pkg::KEY_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fwkc_pkg::t_in_item            i_item,
    input  logic                          i_cfg_we,
    input  logic [fwkc_pkg::CNT_W-1:0]    i_cfg_data,
    input  fwkc_pkg::t_cmd                i_cmd,
    output fwkc_pkg::t_sts                o_sts,
    output fwkc_pkg::t_out_item           o_result,
    output logic                          o_done
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > fwkc_pkg::CNT_W) ? CW : fwkc_pkg::CNT_W;

    fwkc_pkg::t_op        r_op;
    logic [KEY_BITS-1:0]  r_key;
    logic [CW-1:0]        r_count;
    logic [AW-1:0]        r_oldest;
    logic [AW-1:0]        r_rd;
    logic [AW-1:0]        r_wr;
    logic [CW-1:0]        r_idx;
    logic [CW-1:0]        r_matches;
    logic [CW-1:0]        r_kept;
    logic [KEY_BITS-1:0]  r_key_out;
    fwkc_pkg::t_status    r_status;
    logic [fwkc_pkg::CNT_W-1:0] r_limit;
    logic                 r_rd_vld;
    logic                 r_done;
    fwkc_pkg::t_out_item  r_result;

    logic [AW-1:0]        rd_next;
    logic [AW-1:0]        wr_next;
    logic [AW-1:0]        oldest_next;
    logic [CW-1:0]        n_idx;
    logic [AW:0]          tail_sum;
    logic [AW:0]          tail_wrap;
    logic [AW-1:0]        tail;
    logic [LW-1:0]        lim_ext;
    logic [LW-1:0]        lim_eff;
    logic [LW-1:0]        cnt_ext;
    logic [LW-1:0]        mat_ext;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [KEY_BITS-1:0]  ram_wdata;
    logic                 ram_re;
    logic [AW-1:0]        ram_raddr;
    logic [KEY_BITS-1:0]  ram_rdata;
    logic                 hit;
    logic                 keep_wr;

    // ring arithmetic
    assign rd_next     = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
    assign wr_next     = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
    assign oldest_next = (r_oldest == AW'(DEPTH - 1)) ? '0 : r_oldest + AW'(1);
    assign n_idx       = r_idx + CW'(1);

    assign tail_sum  = {1'b0, r_oldest} + (AW+1)'(r_count);
    assign tail_wrap = tail_sum - (AW+1)'(DEPTH);
    assign tail      = (tail_sum >= (AW+1)'(DEPTH)) ? tail_wrap[AW-1:0] : tail_sum[AW-1:0];

    // limit clipped to capacity
    assign lim_ext = LW'(r_limit);
    assign lim_eff = (lim_ext > LW'(DEPTH)) ? LW'(DEPTH) : lim_ext;
    assign cnt_ext = LW'(r_count);
    assign mat_ext = LW'(r_matches);

    assign o_sts.op        = r_op;
    assign o_sts.full      = (cnt_ext >= lim_eff);
    assign o_sts.empty     = (r_count == '0);
    assign o_sts.scan_last = (n_idx == r_count);

    // compare stage of the walk
    assign hit     = (ram_rdata == r_key);
    assign keep_wr = r_rd_vld && !hit && (r_op == fwkc_pkg::OP_PURGE);

    assign ram_we    = i_cmd.enq_write || keep_wr;
    assign ram_waddr = i_cmd.enq_write ? tail : r_wr;
    assign ram_wdata = i_cmd.enq_write ? r_key : ram_rdata;
    assign ram_re    = i_cmd.deq_read || i_cmd.scan_read;
    assign ram_raddr = i_cmd.deq_read ? r_oldest : r_rd;

    fwkc_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_oldest <= '0;
            r_limit  <= fwkc_pkg::LIMIT_RESET;
            r_rd_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.scan_read;
            r_done   <= i_cmd.respond;
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            if (i_cmd.enq_write) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.deq_take) begin
                r_count  <= r_count - CW'(1);
                r_oldest <= oldest_next;
            end else if (i_cmd.commit && (r_op == fwkc_pkg::OP_PURGE)) begin
                r_count <= r_kept;
            end
        end
    end

    // payload and walk registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= i_item.operation;
            r_key     <= KEY_BITS'(i_item.key);
            r_status  <= fwkc_pkg::ST_DONE;
            r_key_out <= '0;
            r_matches <= '0;
            r_kept    <= '0;
        end
        if (i_cmd.set_full) begin
            r_status <= fwkc_pkg::ST_FULL;
        end
        if (i_cmd.set_empty) begin
            r_status <= fwkc_pkg::ST_EMPTY;
        end
        if (i_cmd.deq_take) begin
            r_key_out <= ram_rdata;
        end
        if (i_cmd.scan_init) begin
            r_rd  <= r_oldest;
            r_wr  <= r_oldest;
            r_idx <= '0;
        end
        if (i_cmd.scan_read) begin
            r_rd  <= rd_next;
            r_idx <= n_idx;
        end
        if (r_rd_vld) begin
            if (hit) begin
                r_matches <= r_matches + CW'(1);
            end else begin
                r_kept <= r_kept + CW'(1);
            end
        end
        if (keep_wr) begin
            r_wr <= wr_next;
        end
        if (i_cmd.respond) begin
            r_result.status      <= r_status;
            r_result.key_out     <= fwkc_pkg::KEY_W'(r_key_out);
            r_result.match_count <= mat_ext[fwkc_pkg::CNT_W-1:0];
            r_result.level       <= cnt_ext[fwkc_pkg::CNT_W-1:0];
        end
    end

    assign o_result = r_result;
    assign o_done   = r_done;

endmodule

// ===== hdl/fifo_with_key_count_and_purge.sv =====
// ============================================================================
// fifo_with_key_count_and_purge
// bounded key queue with enqueue, dequeue, count by key and purge by key
// ============================================================================
// A command is taken at a rising edge with start high and busy low, and its
// one result appears on o_result for exactly one cycle with o_done high; the
// receiver cannot stall, so the result must be captured in that cycle.
// Steps from the accepting edge: enqueue and any rejected command go through
// execute and finish, dequeue adds a read wait, count and purge on an empty
// queue go straight to finish, else they read the stored keys one per cycle
// through the single read port of the key store, then pass a drain step for
// the last compare, a commit and a finish step. busy drops as the result is
// shown, so the next command can be taken while o_done is high. The store
// needs no clearing after reset. The limit register is to be written with
// i_cfg_we while the block is idle; the block does not enforce this. A limit
// above DEPTH acts as DEPTH and a limit of zero rejects every enqueue.
// ============================================================================
module fifo_with_key_count_and_purge #(
    parameter int DEPTH    = fwkc_pkg::DEPTH_DEF,
    parameter int KEY_BITS = fwkc_pkg::KEY_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command transfer
    input  logic                          start,
    output logic                          busy,
    input  fwkc_pkg::t_in_item            i_item,
    // result transfer, one cycle strobe
    output logic                          o_done,
    output fwkc_pkg::t_out_item           o_result,
    // limit register
    input  logic                          i_cfg_we,
    input  logic [fwkc_pkg::CNT_W-1:0]    i_cfg_data
);

    // command and status between sequencer and datapath
    fwkc_pkg::t_cmd cmd;
    fwkc_pkg::t_sts sts;

    // sequencer: one command at a time, walk paced by the store read port
    fwkc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // datapath: ring store, pointers, match and keep counters, result register
    fwkc_dp #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_result   (o_result),
        .o_done     (o_done)
    );

endmodule

// ===== tb/sv/tb_fifo_with_key_count_and_purge.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_fifo_with_key_count_and_purge
// self-checking bench for the bounded key queue with count and purge
// ============================================================================
// A queue of pending steps (commands, limit writes and drain points) is built
// up front. A falling-edge driver sends the commands in bursts with random
// gaps, and writes the limit register only when no result is outstanding.
// A rising-edge monitor keeps a shadow copy of the stored keys and the limit,
// works out the response of every accepted command, and compares each strobed
// result with the oldest outstanding response. A directed section covers the
// corner cases; randomized phases then run fill, drain and mixed traffic
// under a range of limits, small key pools making count and purge hit often.
// ============================================================================
module tb_fifo_with_key_count_and_purge;

    localparam int DEPTH        = 32;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int SETTLE_TICKS = 2 * DEPTH + 8;

    // kinds of steps in the stimulus plan
    typedef enum logic [1:0] {
        STEP_COMMAND,
        STEP_LIMIT,
        STEP_DRAIN
    } t_step_kind;

    typedef struct {
        t_step_kind                 kind;
        fwkc_pkg::t_in_item         item;
        logic [fwkc_pkg::CNT_W-1:0] limit;
    } t_plan_step;

    // dut connections; every input known from time zero
    logic                       i_clk      = 1'b0;
    logic                       i_rst_n    = 1'b0;
    logic                       start      = 1'b0;
    fwkc_pkg::t_in_item         i_item     = '0;
    logic                       i_cfg_we   = 1'b0;
    logic [fwkc_pkg::CNT_W-1:0] i_cfg_data = '0;
    logic                       busy;
    logic                       o_done;
    fwkc_pkg::t_out_item        o_result;

    // stimulus plan and handshake bookkeeping
    t_plan_step           plan_q[$];
    fwkc_pkg::t_out_item  awaited_results[$];
    int          n_issued    = 0;
    int          n_taken     = 0;
    int          burst_left  = 1;
    int          gap_left    = 0;
    int          n_errors    = 0;
    int          cycle_count = 0;

    // shadow of the block state
    logic [fwkc_pkg::KEY_W-1:0] shadow_keys[$];
    logic [fwkc_pkg::CNT_W-1:0] shadow_limit = fwkc_pkg::LIMIT_RESET;

    // key pool of the current random phase
    logic [fwkc_pkg::KEY_W-1:0] key_pool[8];
    int                         pool_size = 1;

    fifo_with_key_count_and_purge i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_done     (o_done),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // response of one command, applied to the shadow queue
    function automatic fwkc_pkg::t_out_item queue_response(fwkc_pkg::t_in_item item);
        fwkc_pkg::t_out_item        resp;
        int                         room;
        int                         hits;
        logic [fwkc_pkg::KEY_W-1:0] kept[$];
        resp      = '0;
        resp.status = fwkc_pkg::ST_DONE;
        hits      = 0;
        room      = (shadow_limit > DEPTH) ? DEPTH : int'(shadow_limit);
        case (item.operation)
            fwkc_pkg::OP_ENQUEUE: begin
                if (shadow_keys.size() >= room) begin
                    resp.status = fwkc_pkg::ST_FULL;
                end else begin
                    shadow_keys.push_back(item.key);
                end
            end
            fwkc_pkg::OP_DEQUEUE: begin
                if (shadow_keys.size() == 0) begin
                    resp.status = fwkc_pkg::ST_EMPTY;
                end else begin
                    resp.key_out = shadow_keys.pop_front();
                end
            end
            default: begin
                // count and purge walk the whole queue, purge keeps the rest in order
                foreach (shadow_keys[k]) begin
                    if (shadow_keys[k] == item.key) begin
                        hits++;
                    end else begin
                        kept.push_back(shadow_keys[k]);
                    end
                end
                if (item.operation == fwkc_pkg::OP_PURGE) begin
                    shadow_keys = kept;
                end
            end
        endcase
        resp.match_count = hits[fwkc_pkg::CNT_W-1:0];
        resp.level       = fwkc_pkg::CNT_W'(shadow_keys.size());
        return resp;
    endfunction

    task automatic add_command(fwkc_pkg::t_op op, logic [fwkc_pkg::KEY_W-1:0] key);
        t_plan_step s;
        s.kind           = STEP_COMMAND;
        s.item.operation = op;
        s.item.key       = key;
        s.limit          = '0;
        plan_q.push_back(s);
    endtask

    task automatic add_limit(logic [fwkc_pkg::CNT_W-1:0] value);
        t_plan_step s;
        s.kind  = STEP_LIMIT;
        s.item  = '0;
        s.limit = value;
        plan_q.push_back(s);
    endtask

    task automatic add_drain();
        t_plan_step s;
        s.kind  = STEP_DRAIN;
        s.item  = '0;
        s.limit = '0;
        plan_q.push_back(s);
    endtask

    // mostly keys from the pool so that count and purge find matches
    function automatic logic [fwkc_pkg::KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return key_pool[$urandom_range(0, pool_size - 1)];
        end else if (r < 92) begin
            return fwkc_pkg::KEY_W'($urandom);
        end else if (r < 96) begin
            return '0;
        end
        return '1;
    endfunction

    // driver: changes inputs on the falling edge
    always @(negedge i_clk) begin : drive_steps
        logic                       nxt_start;
        fwkc_pkg::t_in_item         nxt_item;
        logic                       nxt_we;
        logic [fwkc_pkg::CNT_W-1:0] nxt_data;
        t_plan_step                 head;
        nxt_start = start;
        nxt_item  = i_item;
        nxt_we    = 1'b0;
        nxt_data  = i_cfg_data;
        // the command on the bus was taken at the last rising edge
        if (start && n_taken == n_issued) begin
            nxt_start = 1'b0;
        end
        if (i_rst_n && !nxt_start) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (plan_q.size() > 0) begin
                head = plan_q[0];
                case (head.kind)
                    STEP_COMMAND: begin
                        nxt_start = 1'b1;
                        nxt_item  = head.item;
                        n_issued++;
                        void'(plan_q.pop_front());
                        burst_left--;
                        if (burst_left <= 0) begin
                            // new burst; about a quarter of bursts run back to back
                            burst_left = $urandom_range(1, 12);
                            gap_left   = ($urandom_range(0, 3) == 0) ? 0
                                                                     : $urandom_range(1, 10);
                        end
                    end
                    STEP_LIMIT: begin
                        // limit register only changes while nothing is in flight
                        if (awaited_results.size() == 0 && !busy) begin
                            nxt_we   = 1'b1;
                            nxt_data = head.limit;
                            void'(plan_q.pop_front());
                        end
                    end
                    default: begin
                        if (awaited_results.size() == 0) begin
                            void'(plan_q.pop_front());
                        end
                    end
                endcase
            end
        end
        start      <= nxt_start;
        i_item     <= nxt_item;
        i_cfg_we   <= nxt_we;
        i_cfg_data <= nxt_data;
    end

    // monitor: samples on the rising edge
    always @(posedge i_clk) begin : watch_ports
        fwkc_pkg::t_out_item exp_res;
        if (i_rst_n) begin
            if (o_done) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: unexpected result st=%0d key=%h cnt=%0d lvl=%0d", $time,
                             o_result.status, o_result.key_out, o_result.match_count,
                             o_result.level);
                    n_errors++;
                end else begin
                    exp_res = awaited_results.pop_front();
                    if (o_result.status !== exp_res.status
                            || o_result.key_out !== exp_res.key_out
                            || o_result.match_count !== exp_res.match_count
                            || o_result.level !== exp_res.level) begin
                        $display("%0t: mismatch expected st=%0d key=%h cnt=%0d lvl=%0d",
                                 $time, exp_res.status, exp_res.key_out,
                                 exp_res.match_count, exp_res.level);
                        $display("%0t:          actual   st=%0d key=%h cnt=%0d lvl=%0d",
                                 $time, o_result.status, o_result.key_out,
                                 o_result.match_count, o_result.level);
                        n_errors++;
                    end
                end
            end
            if (i_cfg_we) begin
                shadow_limit = i_cfg_data;
            end
            if (start && !busy) begin
                n_taken++;
                awaited_results.push_back(queue_response(i_item));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin : build_and_finish
        int limits[10];
        int modes[10];
        int w_enq;
        int w_deq;
        int w_cnt;
        int r;
        fwkc_pkg::t_op op;
        limits = '{32, 63, 5, 1, 0, 17, 33, 2, 31, 32};
        // 0 fill heavy, 1 drain heavy, 2 mixed
        modes  = '{0, 0, 1, 2, 2, 0, 0, 1, 2, 2};

        // directed: empty queue corners
        add_command(fwkc_pkg::OP_DEQUEUE, 16'hFFFF);
        add_command(fwkc_pkg::OP_COUNT, 16'h0000);
        add_command(fwkc_pkg::OP_PURGE, 16'h0000);
        // extremes of the key and duplicates
        add_command(fwkc_pkg::OP_ENQUEUE, 16'h0000);
        add_command(fwkc_pkg::OP_ENQUEUE, 16'hFFFF);
        add_command(fwkc_pkg::OP_ENQUEUE, 16'h1234);
        add_command(fwkc_pkg::OP_ENQUEUE, 16'hFFFF);
        add_command(fwkc_pkg::OP_ENQUEUE, 16'hA5A5);
        add_command(fwkc_pkg::OP_ENQUEUE, 16'h5A5A);
        add_command(fwkc_pkg::OP_COUNT, 16'hFFFF);
        add_command(fwkc_pkg::OP_COUNT, 16'h0000);
        add_command(fwkc_pkg::OP_COUNT, 16'h7777);
        // purge with no match leaves the queue alone, then a real purge
        add_command(fwkc_pkg::OP_PURGE, 16'h7777);
        add_command(fwkc_pkg::OP_PURGE, 16'hFFFF);
        add_command(fwkc_pkg::OP_DEQUEUE, 16'h0000);
        add_command(fwkc_pkg::OP_DEQUEUE, 16'hAAAA);
        // limit lowered to the level: enqueue rejected, others still work
        add_limit(6'd2);
        add_command(fwkc_pkg::OP_ENQUEUE, 16'h0F0F);
        add_command(fwkc_pkg::OP_COUNT, 16'hA5A5);
        // limit of zero rejects every enqueue, dequeues still empty the queue
        add_limit(6'd0);
        add_command(fwkc_pkg::OP_ENQUEUE, 16'hF0F0);
        add_command(fwkc_pkg::OP_DEQUEUE, 16'h0000);
        add_command(fwkc_pkg::OP_DEQUEUE, 16'h0000);
        add_command(fwkc_pkg::OP_DEQUEUE, 16'h0000);
        add_command(fwkc_pkg::OP_ENQUEUE, 16'h0001);
        add_drain();

        // random phases; no drain between phases so limits drop below the level
        for (int p = 0; p < 10; p++) begin
            pool_size = $urandom_range(2, 8);
            for (int k = 0; k < 8; k++) begin
                key_pool[k] = fwkc_pkg::KEY_W'($urandom);
            end
            add_limit(fwkc_pkg::CNT_W'(limits[p]));
            case (modes[p])
                0:       begin w_enq = 60; w_deq = 10; w_cnt = 18; end
                1:       begin w_enq = 12; w_deq = 58; w_cnt = 18; end
                default: begin w_enq = 36; w_deq = 30; w_cnt = 20; end
            endcase
            for (int n = 0; n < 125; n++) begin
                r = $urandom_range(0, 99);
                if (r < w_enq) begin
                    op = fwkc_pkg::OP_ENQUEUE;
                end else if (r < w_enq + w_deq) begin
                    op = fwkc_pkg::OP_DEQUEUE;
                end else if (r < w_enq + w_deq + w_cnt) begin
                    op = fwkc_pkg::OP_COUNT;
                end else begin
                    op = fwkc_pkg::OP_PURGE;
                end
                add_command(op, pick_key());
                if ($urandom_range(0, 59) == 0) begin
                    add_drain();
                end
            end
            // a random limit value now and then, including ones above capacity
            if (p == 4 || p == 8) begin
                add_limit(fwkc_pkg::CNT_W'($urandom_range(0, 63)));
                add_command(fwkc_pkg::OP_ENQUEUE, pick_key());
                add_command(fwkc_pkg::OP_COUNT, pick_key());
            end
        end

        // reset held low from time zero, then released on a falling edge
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        do begin
            @(posedge i_clk);
        end while (plan_q.size() > 0 || start || awaited_results.size() > 0);
        repeat (SETTLE_TICKS) @(posedge i_clk);

        if (n_errors == 0 && awaited_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== fifo_with_key_count_and_purge.f =====
hdl/fwkc_pkg.sv
hdl/fwkc_ram.sv
hdl/fwkc_ctrl.sv
hdl/fwkc_dp.sv
hdl/fifo_with_key_count_and_purge.sv
tb/sv/tb_fifo_with_key_count_and_purge.sv
